### hdl/pcfr_pkg.sv
package pcfr_pkg;

  // Field widths fixed by the beat format.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PRE_LEN_W  = 4;
  localparam int unsigned EVENT_W    = 2;
  localparam int unsigned OUT_DATA_W = 8;

  // Default payload length of one frame.
  localparam int unsigned PACKET_BYTES_DEF = 8;

  // Register file geometry.
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_PRE_VALUE  = 2'd0;
  localparam logic [1:0] REG_PRE_LENGTH = 2'd1;
  localparam logic [1:0] REG_CMD_FIRST  = 2'd2;
  localparam logic [1:0] REG_CMD_SECOND = 2'd3;

  // Reset values of the registers.
  localparam logic [BYTE_W-1:0]    PRE_VALUE_RST  = 8'h55;
  localparam logic [PRE_LEN_W-1:0] PRE_LENGTH_RST = 4'd4;
  localparam logic [BYTE_W-1:0]    CMD_FIRST_RST  = 8'h14;
  localparam logic [BYTE_W-1:0]    CMD_SECOND_RST = 8'h22;

  // Event reported with a good frame.
  typedef enum logic [EVENT_W-1:0] {
    EV_NONE   = 2'd0,
    EV_FIRST  = 2'd1,
    EV_SECOND = 2'd2
  } event_code_t;

  // Configuration seen by the framer.
  typedef struct packed {
    logic [BYTE_W-1:0]    pre_value;
    logic [PRE_LEN_W-1:0] pre_length;
    logic [BYTE_W-1:0]    cmd_first;
    logic [BYTE_W-1:0]    cmd_second;
  } cfg_t;

  // Result of one received byte.
  typedef struct packed {
    event_code_t event_code;
    logic        checksum_ok;
    logic        frame_done;
  } result_t;

endpackage

### hdl/pcfr_regs.sv
module pcfr_regs
  import pcfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_value  <= PRE_VALUE_RST;
      cfg_r.pre_length <= PRE_LENGTH_RST;
      cfg_r.cmd_first  <= CMD_FIRST_RST;
      cfg_r.cmd_second <= CMD_SECOND_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PRE_VALUE:  cfg_r.pre_value  <= cfg_pwdata[BYTE_W-1:0];
        REG_PRE_LENGTH: cfg_r.pre_length <= cfg_pwdata[PRE_LEN_W-1:0];
        REG_CMD_FIRST:  cfg_r.cmd_first  <= cfg_pwdata[BYTE_W-1:0];
        REG_CMD_SECOND: cfg_r.cmd_second <= cfg_pwdata[BYTE_W-1:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      REG_PRE_VALUE:  cfg_prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, cfg_r.pre_value};
      REG_PRE_LENGTH: cfg_prdata = {{(CFG_DATA_W-PRE_LEN_W){1'b0}}, cfg_r.pre_length};
      REG_CMD_FIRST:  cfg_prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, cfg_r.cmd_first};
      REG_CMD_SECOND: cfg_prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, cfg_r.cmd_second};
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

### hdl/pcfr_framer.sv
module pcfr_framer
  import pcfr_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  input  cfg_t              cfg,
  output result_t           result
);

  localparam int unsigned CNT_W = $clog2(PACKET_BYTES + 1);
  localparam int unsigned SUM_W = BYTE_W + CNT_W;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PACKET_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [PRE_LEN_W-1:0] pre_cnt_r, pre_cnt_nxt;
  logic [CNT_W-1:0]     pay_cnt_r, pay_cnt_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [BYTE_W-1:0]    first_byte_r;
  logic [PRE_LEN_W-1:0] pre_need;
  logic [PRE_LEN_W-1:0] pre_inc;
  logic                 sum_match;

  // A zero preamble length behaves as one.
  assign pre_need  = (cfg.pre_length == '0) ? PRE_LEN_W'(1) : cfg.pre_length;
  assign pre_inc   = pre_cnt_r + PRE_LEN_W'(1);
  assign sum_match = (sum_r == SUM_W'(rx_byte));

  // Next state and the result of this byte.
  always_comb begin
    phase_nxt   = phase_r;
    pre_cnt_nxt = pre_cnt_r;
    pay_cnt_nxt = pay_cnt_r;
    sum_nxt     = sum_r;
    result      = '{event_code: EV_NONE, checksum_ok: 1'b0, frame_done: 1'b0};
    unique case (phase_r)
      PH_PAYLOAD: begin
        sum_nxt     = sum_r + SUM_W'(rx_byte);
        pay_cnt_nxt = pay_cnt_r + CNT_W'(1);
        if (pay_cnt_r == LAST_IDX) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        result.frame_done = 1'b1;
        if (sum_match) begin
          result.checksum_ok = 1'b1;
          if (first_byte_r == cfg.cmd_first) begin
            result.event_code = EV_FIRST;
          end else if (first_byte_r == cfg.cmd_second) begin
            result.event_code = EV_SECOND;
          end
        end
        phase_nxt   = PH_HUNT;
        pre_cnt_nxt = '0;
        pay_cnt_nxt = '0;
        sum_nxt     = '0;
      end
      default: begin
        if (rx_byte == cfg.pre_value) begin
          pre_cnt_nxt = pre_inc;
          if (pre_inc >= pre_need) begin
            phase_nxt   = PH_PAYLOAD;
            pay_cnt_nxt = '0;
            sum_nxt     = '0;
          end
        end else begin
          phase_nxt   = PH_HUNT;
          pre_cnt_nxt = '0;
          pay_cnt_nxt = '0;
          sum_nxt     = '0;
        end
      end
    endcase
  end

  // Frame state advances once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      pre_cnt_r <= '0;
      pay_cnt_r <= '0;
      sum_r     <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      pre_cnt_r <= pre_cnt_nxt;
      pay_cnt_r <= pay_cnt_nxt;
      sum_r     <= sum_nxt;
    end
  end

  // The first payload byte is kept for the command match.
  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_PAYLOAD && pay_cnt_r == '0) begin
      first_byte_r <= rx_byte;
    end
  end

endmodule

### hdl/pcfr_out_stage.sv
module pcfr_out_stage
  import pcfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  result_t               result,
  output logic                  free,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic    valid_r;
  result_t data_r;

  // The stage can take a new result when empty or being drained.
  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

### hdl/preamble_checksum_frame_receiver_unit.sv
// Preamble-framed packet receiver: takes one received byte per input beat and
// returns one result beat for each. It hunts for a run of preamble bytes,
// collects PACKET_BYTES payload bytes, and checks the next byte against their
// plain sum; a good frame reports whether its first payload byte matches one of
// two command codes. Every byte is handled by the combinational framer logic
// and lands in a single output register, so a byte is accepted every cycle
// while the result side keeps up; in_tready drops only while that register
// holds a beat that is not being taken. The user must write registers over the
// APB port only while no beat is in flight; the block does not enforce this.
module preamble_checksum_frame_receiver_unit
  import pcfr_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Received byte stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] frame_done, [1] checksum_ok,
                                            // [3:2] event_code, [7:4] zero
  // Register port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t    cfg;
  result_t result;
  logic    free;
  logic    accept;

  assign in_tready = free;
  assign accept    = in_tvalid & free;

  pcfr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pcfr_framer #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_tdata),
    .cfg     (cfg),
    .result  (result)
  );

  pcfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .result     (result),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### hdl/pcfr_checker.sv
module pcfr_checker
  import pcfr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A held result beat stays valid until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped before it was taken");

  // Every accepted byte yields a result beat in the next cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted byte produced no result beat");

  // With the output register empty the input side is open.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  // A good checksum only comes with a frame end.
  a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0])
    else $error("checksum_ok without frame_done");

  // An event needs a good checksum and is never the unused code.
  a_event_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:2] != 2'd0 |-> out_tdata[1] && out_tdata[3:2] != 2'd3)
    else $error("event reported without a good checksum");

endmodule

bind preamble_checksum_frame_receiver_unit pcfr_checker u_pcfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### test/frame_result_checker.sv
// Watches the byte stream, the result stream and the register port of the
// frame receiver. Every accepted byte is run through a local copy of the
// framer, and the status it should produce is queued; every accepted result
// beat is compared field by field with the oldest queued status.
module frame_result_checker
  import pcfr_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [0] frame_done, [1] checksum_ok,
                                            // [3:2] event_code, [7:4] zero
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    fail_count,
  output int                    pending,
  output int                    frames_closed,
  output int                    frames_good,
  output int                    first_events,
  output int                    second_events
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } rx_phase_t;

  // Local copy of the registers and of the framer state.
  cfg_t                regs;
  rx_phase_t           rx_phase;
  logic [PRE_LEN_W-1:0] run_len;
  logic [6:0]          byte_idx;
  logic [13:0]         byte_total;
  logic [BYTE_W-1:0]   lead_byte;

  result_t status_q[$];
  int      errs;

  function automatic void restart_hunt();
    rx_phase   = PH_HUNT;
    run_len    = '0;
    byte_idx   = '0;
    byte_total = '0;
  endfunction

  // Advances the framer by one received byte and returns its status.
  function automatic result_t decode_rx_byte(input logic [BYTE_W-1:0] b);
    result_t              r;
    logic [PRE_LEN_W-1:0] need;
    r.frame_done  = 1'b0;
    r.checksum_ok = 1'b0;
    r.event_code  = EV_NONE;
    case (rx_phase)
      PH_PAYLOAD: begin
        if (byte_idx == 7'd0) begin
          lead_byte = b;
        end
        byte_total = byte_total + 14'(b);
        byte_idx   = byte_idx + 7'd1;
        if (byte_idx >= PACKET_BYTES) begin
          rx_phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        // The whole sum must match, so a sum above 255 never passes.
        r.frame_done = 1'b1;
        if (byte_total == 14'(b)) begin
          r.checksum_ok = 1'b1;
          if (lead_byte == regs.cmd_first) begin
            r.event_code = EV_FIRST;
          end else if (lead_byte == regs.cmd_second) begin
            r.event_code = EV_SECOND;
          end
        end
        restart_hunt();
      end
      default: begin
        // A length of zero behaves as a length of one.
        if (b == regs.pre_value) begin
          need    = (regs.pre_length == '0) ? PRE_LEN_W'(1) : regs.pre_length;
          run_len = run_len + PRE_LEN_W'(1);
          if (run_len >= need) begin
            rx_phase   = PH_PAYLOAD;
            byte_idx   = '0;
            byte_total = '0;
          end
        end else begin
          restart_hunt();
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_PRE_VALUE:  return CFG_DATA_W'(regs.pre_value);
      REG_PRE_LENGTH: return CFG_DATA_W'(regs.pre_length);
      REG_CMD_FIRST:  return CFG_DATA_W'(regs.cmd_first);
      default:        return CFG_DATA_W'(regs.cmd_second);
    endcase
  endfunction

  always @(posedge clk) begin
    result_t               want;
    logic [CFG_DATA_W-1:0] rd_want;
    if (!rst_n) begin
      regs.pre_value  = PRE_VALUE_RST;
      regs.pre_length = PRE_LENGTH_RST;
      regs.cmd_first  = CMD_FIRST_RST;
      regs.cmd_second = CMD_SECOND_RST;
      restart_hunt();
      lead_byte = '0;
      status_q.delete();
      errs = 0;
      frames_closed <= 0;
      frames_good   <= 0;
      first_events  <= 0;
      second_events <= 0;
    end else begin
      // Register writes update the local copy; reads are checked against it.
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr[3:2])
            REG_PRE_VALUE:  regs.pre_value  = cfg_pwdata[BYTE_W-1:0];
            REG_PRE_LENGTH: regs.pre_length = cfg_pwdata[PRE_LEN_W-1:0];
            REG_CMD_FIRST:  regs.cmd_first  = cfg_pwdata[BYTE_W-1:0];
            default:        regs.cmd_second = cfg_pwdata[BYTE_W-1:0];
          endcase
        end else begin
          rd_want = reg_value(cfg_paddr[3:2]);
          if (cfg_prdata !== rd_want) begin
            $error("cfg_prdata: expected %h, actual %h", rd_want, cfg_prdata);
            errs++;
          end
        end
      end

      // Each accepted byte queues the status it must produce.
      if (in_tvalid && in_tready) begin
        want = decode_rx_byte(in_tdata);
        status_q.push_back(want);
        if (want.frame_done) begin
          frames_closed <= frames_closed + 1;
        end
        if (want.checksum_ok) begin
          frames_good <= frames_good + 1;
        end
        if (want.event_code == EV_FIRST) begin
          first_events <= first_events + 1;
        end
        if (want.event_code == EV_SECOND) begin
          second_events <= second_events + 1;
        end
      end

      // Each accepted result beat is matched with the oldest queued status.
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          $error("result beat %h arrived with no byte awaiting a result", out_tdata);
          errs++;
        end else begin
          want = status_q.pop_front();
          if (out_tdata[0] !== want.frame_done) begin
            $error("frame_done: expected %0d, actual %0d", want.frame_done, out_tdata[0]);
            errs++;
          end
          if (out_tdata[1] !== want.checksum_ok) begin
            $error("checksum_ok: expected %0d, actual %0d", want.checksum_ok,
                   out_tdata[1]);
            errs++;
          end
          if (out_tdata[3:2] !== want.event_code) begin
            $error("event_code: expected %0d, actual %0d", want.event_code,
                   out_tdata[3:2]);
            errs++;
          end
          if (out_tdata[7:4] !== 4'd0) begin
            $error("out_tdata padding: expected 0, actual %0d", out_tdata[7:4]);
            errs++;
          end
        end
      end
    end
    pending    <= status_q.size();
    fail_count <= errs;
  end

endmodule

### test/testbench.sv
// Drives bytes, result back-pressure and register settings into the frame
// receiver and gives the verdict from the checker's counts.
module testbench;
  import pcfr_pkg::*;

  localparam int unsigned PKT       = PACKET_BYTES_DEF;
  localparam int          LIMIT     = 200000;
  localparam int          SET_BYTES = 250;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count, pending, frames_closed, frames_good, first_events, second_events;
  int cycles   = 0;
  int sent     = 0;
  int settings = 0;
  bit steady   = 1'b0;

  // Settings currently loaded, used to build frames.
  logic [BYTE_W-1:0]    cur_pv;
  logic [PRE_LEN_W-1:0] cur_len;
  logic [BYTE_W-1:0]    cur_c1;
  logic [BYTE_W-1:0]    cur_c2;

  preamble_checksum_frame_receiver_unit #(.PACKET_BYTES(PKT)) dut (.*);

  frame_result_checker #(.PACKET_BYTES(PKT)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side stalls at random unless a steady stretch is running.
  always @(posedge clk) begin
    out_tready <= rst_n && (steady || $urandom_range(0, 99) >= 16);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one byte, with a random gap first, and waits for its acceptance.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Stops sending until every queued status has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic reg_access(input bit wr, input logic [1:0] idx,
                            input logic [CFG_DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_back();
    reg_access(1'b0, REG_PRE_VALUE, '0);
    reg_access(1'b0, REG_PRE_LENGTH, '0);
    reg_access(1'b0, REG_CMD_FIRST, '0);
    reg_access(1'b0, REG_CMD_SECOND, '0);
  endtask

  task automatic apply_settings(input logic [BYTE_W-1:0] pv,
                                input logic [PRE_LEN_W-1:0] len,
                                input logic [BYTE_W-1:0] c1,
                                input logic [BYTE_W-1:0] c2);
    drain();
    cur_pv  = pv;
    cur_len = len;
    cur_c1  = c1;
    cur_c2  = c2;
    reg_access(1'b1, REG_PRE_VALUE, CFG_DATA_W'(pv));
    reg_access(1'b1, REG_PRE_LENGTH, CFG_DATA_W'(len));
    reg_access(1'b1, REG_CMD_FIRST, CFG_DATA_W'(c1));
    reg_access(1'b1, REG_CMD_SECOND, CFG_DATA_W'(c2));
    read_back();
    settings++;
  endtask

  function automatic logic [BYTE_W-1:0] not_preamble();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    return (b == cur_pv) ? ~b : b;
  endfunction

  // One frame with random content: mostly well formed, sometimes preceded
  // by noise or a cut-off preamble, with a checksum that is mostly right.
  task automatic send_frame();
    logic [BYTE_W-1:0] body[PKT];
    int                need;
    int                cap;
    int                total;
    int                pick;
    bit                fit;
    logic [BYTE_W-1:0] chk;
    need = (cur_len == 0) ? 1 : int'(cur_len);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, need - 1)) send_byte(cur_pv);
      send_byte(not_preamble());
    end
    repeat (need) send_byte(cur_pv);
    pick = $urandom_range(0, 9);
    body[0] = (pick < 4) ? cur_c1 : (pick < 8) ? cur_c2 : BYTE_W'($urandom_range(0, 255));
    cap   = (PKT > 1) ? (255 - int'(body[0])) / (PKT - 1) : 0;
    fit   = $urandom_range(0, 9) < 6;
    total = body[0];
    for (int i = 1; i < PKT; i++) begin
      body[i] = fit ? BYTE_W'($urandom_range(0, cap)) : BYTE_W'($urandom_range(0, 255));
      total  += body[i];
    end
    // The low byte of an overflowed sum must still be rejected.
    pick = $urandom_range(0, 19);
    if (pick < 15) begin
      chk = BYTE_W'(total);
    end else if (pick < 18) begin
      chk = BYTE_W'(total) ^ BYTE_W'($urandom_range(1, 255));
    end else begin
      chk = BYTE_W'($urandom_range(0, 255));
    end
    for (int i = 0; i < PKT; i++) begin
      send_byte(body[i]);
    end
    send_byte(chk);
  endtask

  initial begin
    int goal;
    int acc;
    bit paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, checked by reading them back.
    cur_pv  = PRE_VALUE_RST;
    cur_len = PRE_LENGTH_RST;
    cur_c1  = CMD_FIRST_RST;
    cur_c2  = CMD_SECOND_RST;
    read_back();
    settings++;

    // Byte extremes, a preamble broken by another byte, then a good frame
    // carrying the first command.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(PRE_VALUE_RST);
    send_byte(PRE_VALUE_RST);
    send_byte(8'h00);
    repeat (PRE_LENGTH_RST) send_byte(PRE_VALUE_RST);
    send_byte(CMD_FIRST_RST);
    acc = CMD_FIRST_RST;
    for (int i = 1; i < PKT; i++) begin
      send_byte(BYTE_W'(i));
      acc += i;
    end
    send_byte(BYTE_W'(acc));

    goal = sent + 150;
    while (sent < goal) send_frame();

    // A series of settings, extremes first, then random ones.
    for (int p = 1; p <= 7; p++) begin
      case (p)
        1: apply_settings(8'h00, 4'd1, 8'h00, 8'hFF);
        2: apply_settings(8'hFF, 4'd15, 8'hFF, 8'h00);
        3: begin
          // Zero length acts as one; equal codes favor the first event.
          acc = $urandom_range(0, 255);
          apply_settings(BYTE_W'($urandom_range(0, 255)), 4'd0, BYTE_W'(acc), BYTE_W'(acc));
        end
        7: apply_settings(BYTE_W'($urandom_range(0, 255)), PRE_LEN_W'($urandom_range(1, 15)),
                          BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
        default: apply_settings(BYTE_W'($urandom_range(0, 255)),
                                PRE_LEN_W'($urandom_range(1, 6)),
                                BYTE_W'($urandom_range(0, 255)),
                                BYTE_W'($urandom_range(0, 255)));
      endcase
      steady <= (p == 6);
      goal = sent + SET_BYTES;
      while (sent < goal) begin
        send_frame();
        if (p == 4 && !paused && sent >= goal - SET_BYTES / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    $display("tb: %0d bytes sent under %0d register settings, %0d frames closed",
             sent, settings, frames_closed);
    $display("tb: %0d frames passed the checksum, %0d first and %0d second command events",
             frames_good, first_events, second_events);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
hdl/pcfr_pkg.sv
hdl/pcfr_regs.sv
hdl/pcfr_framer.sv
hdl/pcfr_out_stage.sv
hdl/preamble_checksum_frame_receiver_unit.sv
hdl/pcfr_checker.sv
test/frame_result_checker.sv
test/testbench.sv
